// ===== design/bsfe_pkg.sv =====
// Package for the battery SOH fade estimator: widths, constants, register
// indexes and the microcode program of the sequencer.
// No dependencies.
`default_nettype none

package bsfe_pkg;

    localparam int CYC_W      = 16;
    localparam int TCAP_W     = 24;
    localparam int SOH_W      = 10;
    localparam int RCAP_W     = 16;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_NUM_W  = 28;
    localparam int DIV_DEN_W  = 16;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 10;

    // x/1000 as ((x >> 3) * ceil(2^30/125)) >> 30, exact for x below 2^26
    localparam int FADE_PRE_SH   = 3;
    localparam int FADE_RECIP_W  = 24;
    localparam int FADE_RECIP_SH = 30;
    localparam logic [FADE_RECIP_W-1:0] FADE_RECIP = 24'd8589935;

    localparam logic [CFG_IDX_W-1:0] CFG_RATED_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATED_CYCLES   = 8'd1;

    localparam logic [RCAP_W-1:0] RATED_CAP_RST = 16'd1000;
    localparam logic [CYC_W-1:0]  RATED_CYC_RST = 16'd1000;
    localparam logic [RCAP_W-1:0] FADE_RST      = 16'd1000;

    localparam logic [SOH_W-1:0]   SOH_FULL     = 10'd1000;
    localparam logic [SOH_W-1:0]   SOH_EOL      = 10'd800;
    localparam logic [SOH_W-1:0]   SOH_BAND     = 10'd50;
    localparam logic [SOH_W-1:0]   SOH_MAX_DROP = 10'd5;
    localparam logic [MUL_B_W-1:0] CYC_SPAN     = 10'd200;
    localparam logic [MUL_B_W-1:0] CAP_SCALE    = 10'd10;

    localparam int PC_W = 5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_MUL_CAP,
        OP_DIV_CAP,
        OP_SET_CAP,
        OP_MUL_CYC,
        OP_DIV_CYC,
        OP_SET_CYC,
        OP_PICK,
        OP_MUL_FADE,
        OP_SET_FADE,
        OP_MUL_REAL,
        OP_DIV_REAL,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_RECOMP,
        C_DIV_BUSY,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucw_t;

    // jump labels
    localparam logic [PC_W-1:0] L_IDLE      = 5'd0;
    localparam logic [PC_W-1:0] L_WAIT_CAP  = 5'd4;
    localparam logic [PC_W-1:0] L_WAIT_CYC  = 5'd8;
    localparam logic [PC_W-1:0] L_REAL      = 5'd13;
    localparam logic [PC_W-1:0] L_WAIT_REAL = 5'd15;
    localparam logic [PC_W-1:0] L_EMIT      = 5'd16;

    function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
        ucw_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: L_IDLE};
        case (pc)
            5'd0:  w = '{op: OP_LATCH,    cond: C_NO_INPUT,   target: L_IDLE};
            5'd1:  w = '{op: OP_NOP,      cond: C_NOT_RECOMP, target: L_REAL};
            5'd2:  w = '{op: OP_MUL_CAP,  cond: C_NEXT,       target: L_IDLE};
            5'd3:  w = '{op: OP_DIV_CAP,  cond: C_NEXT,       target: L_IDLE};
            5'd4:  w = '{op: OP_NOP,      cond: C_DIV_BUSY,   target: L_WAIT_CAP};
            5'd5:  w = '{op: OP_SET_CAP,  cond: C_NEXT,       target: L_IDLE};
            5'd6:  w = '{op: OP_MUL_CYC,  cond: C_NEXT,       target: L_IDLE};
            5'd7:  w = '{op: OP_DIV_CYC,  cond: C_NEXT,       target: L_IDLE};
            5'd8:  w = '{op: OP_NOP,      cond: C_DIV_BUSY,   target: L_WAIT_CYC};
            5'd9:  w = '{op: OP_SET_CYC,  cond: C_NEXT,       target: L_IDLE};
            5'd10: w = '{op: OP_PICK,     cond: C_NEXT,       target: L_IDLE};
            5'd11: w = '{op: OP_MUL_FADE, cond: C_NEXT,       target: L_IDLE};
            5'd12: w = '{op: OP_SET_FADE, cond: C_NEXT,       target: L_IDLE};
            5'd13: w = '{op: OP_MUL_REAL, cond: C_NEXT,       target: L_IDLE};
            5'd14: w = '{op: OP_DIV_REAL, cond: C_NEXT,       target: L_IDLE};
            5'd15: w = '{op: OP_NOP,      cond: C_DIV_BUSY,   target: L_WAIT_REAL};
            5'd16: w = '{op: OP_EMIT,     cond: C_OUT_FULL,   target: L_EMIT};
            5'd17: w = '{op: OP_NOP,      cond: C_ALWAYS,     target: L_IDLE};
            default: w = '{op: OP_NOP,    cond: C_ALWAYS,     target: L_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/bsfe_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle, start/busy control.
// Depends on bsfe_pkg for default widths.
`default_nettype none

module bsfe_div #(
    parameter int NUM_W = bsfe_pkg::DIV_NUM_W,
    parameter int DEN_W = bsfe_pkg::DIV_DEN_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic      [NUM_W-1:0] quo
);

    localparam int STEPS = (NUM_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [PAD_W-1:0] sh_reg, sh_next;

    logic [DEN_W:0] t1, r1, t2, r2;
    logic           ge1, ge2;

    always_comb begin
        t1  = {rem_reg, sh_reg[PAD_W-1]};
        ge1 = t1 >= {1'b0, den_reg};
        r1  = ge1 ? t1 - {1'b0, den_reg} : t1;
        t2  = {r1[DEN_W-1:0], sh_reg[PAD_W-2]};
        ge2 = t2 >= {1'b0, den_reg};
        r2  = ge2 ? t2 - {1'b0, den_reg} : t2;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            rem_next  = '0;
            den_next  = den;
            sh_next   = PAD_W'(num);
        end else if (busy_reg) begin
            sh_next   = {sh_reg[PAD_W-3:0], ge1, ge2};
            rem_next  = r2[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
    end

    assign busy = busy_reg;
    assign quo  = sh_reg[NUM_W-1:0];

endmodule

`default_nettype wire

// ===== design/battery_soh_fade_estimator.sv =====
// Battery SOH fade estimator top level: microcoded sequencer and datapath.
// Depends on bsfe_pkg and bsfe_div.
//
// One input beat per tick, one result beat per input beat. A tick whose cycle
// count differs from the last one recorded (or while that count is zero)
// recomputes the SOH and the faded capacity; every tick reports the faded
// capacity and the real SOH. The sequencer runs an 18-step program from a
// constant table over one shared 24x10 multiplier, a reciprocal multiplier for
// the divide by 1000, and one shared divider that yields two quotient bits per
// cycle. A recomputing tick uses three divides; any other tick uses one divide.
// s_tready returns in the cycle after the result is loaded into the output
// register, while that result waits to be taken.
// Configuration writes are always ready.
`default_nettype none

module battery_soh_fade_estimator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [15:0] cycle_count, [39:16] total_capacity, [49:40] present_soh
    input  wire logic [bsfe_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [9:0] new_soh, [10] store_request, [26:11] faded_capacity, [36:27] real_soh
    output logic      [bsfe_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] recomputed
    output logic                                     m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bsfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bsfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SOH_W  = bsfe_pkg::SOH_W;
    localparam int CYC_W  = bsfe_pkg::CYC_W;
    localparam int TCAP_W = bsfe_pkg::TCAP_W;
    localparam int RCAP_W = bsfe_pkg::RCAP_W;
    localparam int NUM_W  = bsfe_pkg::DIV_NUM_W;
    localparam int DEN_W  = bsfe_pkg::DIV_DEN_W;
    localparam int MA_W   = bsfe_pkg::MUL_A_W;
    localparam int MB_W   = bsfe_pkg::MUL_B_W;
    localparam int PC_W   = bsfe_pkg::PC_W;
    localparam int FP_W   = NUM_W - bsfe_pkg::FADE_PRE_SH + bsfe_pkg::FADE_RECIP_W;

    bsfe_pkg::ucw_t uc;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [RCAP_W-1:0] rated_cap_reg, rated_cap_next;
    logic [CYC_W-1:0]  rated_cyc_reg, rated_cyc_next;
    logic [CYC_W-1:0]  last_reg, last_next;
    logic [RCAP_W-1:0] fade_reg, fade_next;
    logic              out_valid_reg, out_valid_next;

    logic [CYC_W-1:0]  cyc_in_reg, cyc_in_next;
    logic [TCAP_W-1:0] tcap_in_reg, tcap_in_next;
    logic [SOH_W-1:0]  present_reg, present_next;
    logic              recomp_reg, recomp_next;
    logic [NUM_W-1:0]  prod_reg, prod_next;
    logic [SOH_W-1:0]  cap_soh_reg, cap_soh_next;
    logic [SOH_W-1:0]  cyc_soh_reg, cyc_soh_next;
    logic [SOH_W-1:0]  soh_reg, soh_next;
    logic              out_recomp_reg, out_recomp_next;
    logic [SOH_W-1:0]  out_soh_reg, out_soh_next;
    logic              out_store_reg, out_store_next;
    logic [RCAP_W-1:0] out_fade_reg, out_fade_next;
    logic [SOH_W-1:0]  out_real_reg, out_real_next;

    logic              jump, out_blocked, in_take, div_start, div_busy;
    logic [MA_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [MA_W+MB_W-1:0] prod_full;
    logic [FP_W-1:0]   fade_prod;
    logic [RCAP_W-1:0] fade_quo;
    logic [DEN_W-1:0]  div_den;
    logic [NUM_W-1:0]  div_quo;
    logic [SOH_W:0]    sum_soh;
    logic [SOH_W-1:0]  avg_soh, diff_soh, pick;
    logic [SOH_W-1:0]  quo_sat;

    bsfe_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    always_comb begin
        uc          = bsfe_pkg::ucode(pc_reg);
        out_blocked = out_valid_reg && !m_tready;
        s_tready    = (pc_reg == bsfe_pkg::L_IDLE);
        in_take     = s_tvalid && s_tready;
        cfg_ready   = 1'b1;

        case (uc.cond)
            bsfe_pkg::C_NEXT:       jump = 1'b0;
            bsfe_pkg::C_ALWAYS:     jump = 1'b1;
            bsfe_pkg::C_NO_INPUT:   jump = !s_tvalid;
            bsfe_pkg::C_NOT_RECOMP: jump = !recomp_reg;
            bsfe_pkg::C_DIV_BUSY:   jump = div_busy;
            bsfe_pkg::C_OUT_FULL:   jump = out_blocked;
            default:                jump = 1'b1;
        endcase
        pc_next = jump ? uc.target : pc_reg + PC_W'(1);

        // shared multiplier operands
        case (uc.op)
            bsfe_pkg::OP_MUL_CAP: begin
                mul_a = tcap_in_reg;
                mul_b = bsfe_pkg::CAP_SCALE;
            end
            bsfe_pkg::OP_MUL_CYC: begin
                mul_a = MA_W'(cyc_in_reg);
                mul_b = bsfe_pkg::CYC_SPAN;
            end
            bsfe_pkg::OP_MUL_FADE: begin
                mul_a = MA_W'(rated_cap_reg);
                mul_b = soh_reg;
            end
            default: begin
                mul_a = MA_W'(fade_reg);
                mul_b = bsfe_pkg::SOH_FULL;
            end
        endcase
        prod_full = mul_a * mul_b;

        // faded capacity: rated capacity times SOH over 1000
        fade_prod = prod_reg[NUM_W-1:bsfe_pkg::FADE_PRE_SH] * bsfe_pkg::FADE_RECIP;
        fade_quo  = fade_prod[bsfe_pkg::FADE_RECIP_SH +: RCAP_W];

        div_start = (uc.op == bsfe_pkg::OP_DIV_CAP) || (uc.op == bsfe_pkg::OP_DIV_CYC) ||
                    (uc.op == bsfe_pkg::OP_DIV_REAL);
        case (uc.op)
            bsfe_pkg::OP_DIV_CYC:  div_den = rated_cyc_reg;
            default:               div_den = rated_cap_reg;
        endcase

        // quotient saturated at full scale, zero when rated capacity is zero
        if (rated_cap_reg == '0)
            quo_sat = '0;
        else if (div_quo > NUM_W'(bsfe_pkg::SOH_FULL))
            quo_sat = bsfe_pkg::SOH_FULL;
        else
            quo_sat = div_quo[SOH_W-1:0];

        sum_soh  = {1'b0, cap_soh_reg} + {1'b0, cyc_soh_reg};
        avg_soh  = sum_soh[SOH_W:1];
        diff_soh = (cap_soh_reg > cyc_soh_reg) ? cap_soh_reg - cyc_soh_reg
                                               : cyc_soh_reg - cap_soh_reg;
        if (diff_soh <= bsfe_pkg::SOH_BAND)
            pick = cyc_soh_reg;
        else if (avg_soh > present_reg)
            pick = present_reg;
        else if (present_reg - avg_soh > bsfe_pkg::SOH_MAX_DROP)
            pick = present_reg - bsfe_pkg::SOH_MAX_DROP;
        else
            pick = avg_soh;
        if (pick > bsfe_pkg::SOH_FULL)
            pick = bsfe_pkg::SOH_FULL;

        rated_cap_next  = rated_cap_reg;
        rated_cyc_next  = rated_cyc_reg;
        last_next       = last_reg;
        fade_next       = fade_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        cyc_in_next     = cyc_in_reg;
        tcap_in_next    = tcap_in_reg;
        present_next    = present_reg;
        recomp_next     = recomp_reg;
        prod_next       = prod_reg;
        cap_soh_next    = cap_soh_reg;
        cyc_soh_next    = cyc_soh_reg;
        soh_next        = soh_reg;
        out_recomp_next = out_recomp_reg;
        out_soh_next    = out_soh_reg;
        out_store_next  = out_store_reg;
        out_fade_next   = out_fade_reg;
        out_real_next   = out_real_reg;

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == bsfe_pkg::CFG_RATED_CAPACITY)
                rated_cap_next = cfg_data;
            else if (cfg_index == bsfe_pkg::CFG_RATED_CYCLES)
                rated_cyc_next = cfg_data;
        end

        case (uc.op)
            bsfe_pkg::OP_LATCH: begin
                if (in_take) begin
                    cyc_in_next  = s_tdata[15:0];
                    tcap_in_next = s_tdata[39:16];
                    present_next = s_tdata[49:40];
                    recomp_next  = (last_reg == '0) || (s_tdata[15:0] != last_reg);
                end
            end
            bsfe_pkg::OP_MUL_CAP, bsfe_pkg::OP_MUL_CYC,
            bsfe_pkg::OP_MUL_FADE, bsfe_pkg::OP_MUL_REAL: begin
                prod_next = prod_full[NUM_W-1:0];
            end
            bsfe_pkg::OP_SET_CAP: cap_soh_next = quo_sat;
            bsfe_pkg::OP_SET_CYC: begin
                if (rated_cyc_reg != '0 && rated_cyc_reg >= cyc_in_reg)
                    cyc_soh_next = bsfe_pkg::SOH_FULL - div_quo[SOH_W-1:0];
                else
                    cyc_soh_next = bsfe_pkg::SOH_EOL;
            end
            bsfe_pkg::OP_PICK: soh_next = pick;
            bsfe_pkg::OP_SET_FADE: begin
                fade_next = fade_quo;
                last_next = cyc_in_reg;
            end
            bsfe_pkg::OP_EMIT: begin
                if (!out_blocked) begin
                    out_valid_next  = 1'b1;
                    out_recomp_next = recomp_reg;
                    out_soh_next    = recomp_reg ? soh_reg : '0;
                    out_store_next  = recomp_reg && (soh_reg != present_reg);
                    out_fade_next   = fade_reg;
                    out_real_next   = quo_sat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= bsfe_pkg::L_IDLE;
            rated_cap_reg <= bsfe_pkg::RATED_CAP_RST;
            rated_cyc_reg <= bsfe_pkg::RATED_CYC_RST;
            last_reg      <= '0;
            fade_reg      <= bsfe_pkg::FADE_RST;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            rated_cap_reg <= rated_cap_next;
            rated_cyc_reg <= rated_cyc_next;
            last_reg      <= last_next;
            fade_reg      <= fade_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cyc_in_reg     <= cyc_in_next;
        tcap_in_reg    <= tcap_in_next;
        present_reg    <= present_next;
        recomp_reg     <= recomp_next;
        prod_reg       <= prod_next;
        cap_soh_reg    <= cap_soh_next;
        cyc_soh_reg    <= cyc_soh_next;
        soh_reg        <= soh_next;
        out_recomp_reg <= out_recomp_next;
        out_soh_reg    <= out_soh_next;
        out_store_reg  <= out_store_next;
        out_fade_reg   <= out_fade_next;
        out_real_reg   <= out_real_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_recomp_reg;
    assign m_tdata  = {3'b000, out_real_reg, out_fade_reg, out_store_reg, out_soh_reg};

endmodule

`default_nettype wire

// ===== design/bsfe_checker.sv =====
// Port-level checks for the battery SOH fade estimator, bound to the top level.
// Depends on bsfe_pkg and battery_soh_fade_estimator.
`default_nettype none

module bsfe_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bsfe_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    // a beat without recompute carries no SOH and no store request
    a_no_recomp_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[9:0] == '0 && !m_tdata[10]))
        else $error("non-recompute beat carries SOH or store request");

    a_soh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:0] <= bsfe_pkg::SOH_FULL &&
                      m_tdata[36:27] <= bsfe_pkg::SOH_FULL))
        else $error("SOH above full scale");

    // one beat in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after accepting a beat");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind battery_soh_fade_estimator bsfe_checker u_bsfe_checker (.*);

`default_nettype wire

// ===== dv/bsfe_checker.sv =====
// Scoreboard for the battery SOH fade estimator: watches the config, input and
// result channels, predicts each result beat and compares it field by field.
// Depends on bsfe_pkg.
`default_nettype none

module bsfe_scoreboard (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [bsfe_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [bsfe_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                            m_tuser,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [bsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bsfe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   errors,
    output int                                   outstanding
);

    localparam int SOH_W  = bsfe_pkg::SOH_W;
    localparam int RCAP_W = bsfe_pkg::RCAP_W;
    localparam int CYC_W  = bsfe_pkg::CYC_W;
    localparam int TCAP_W = bsfe_pkg::TCAP_W;

    typedef struct packed {
        logic              recomputed;
        logic [SOH_W-1:0]  new_soh;
        logic              store_request;
        logic [RCAP_W-1:0] faded_capacity;
        logic [SOH_W-1:0]  real_soh;
    } tick_result_t;

    tick_result_t      soh_expected_q[$];
    logic [RCAP_W-1:0] rated_cap;
    logic [CYC_W-1:0]  rated_cyc;
    logic [CYC_W-1:0]  last_cyc;
    logic [RCAP_W-1:0] fade_cap;

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // SOH choice from capacity and cycle estimates, with the limited drop
    function automatic int unsigned choose_soh(input int unsigned cyc, input int unsigned tcap,
                                               input int unsigned present);
        int unsigned cap_soh;
        int unsigned cyc_soh;
        int unsigned diff;
        int unsigned pick;
        cap_soh = 0;
        if (rated_cap != 0) begin
            cap_soh = (tcap * 10) / rated_cap;
            if (cap_soh > 1000) cap_soh = 1000;
        end
        if (rated_cyc != 0 && rated_cyc >= cyc)
            cyc_soh = 1000 - (cyc * 200) / rated_cyc;
        else
            cyc_soh = 800;
        diff = (cap_soh > cyc_soh) ? cap_soh - cyc_soh : cyc_soh - cap_soh;
        if (diff <= 50) begin
            pick = cyc_soh;
        end else begin
            pick = (cap_soh + cyc_soh) / 2;
            if (pick > present)
                pick = present;
            else if (present - pick > 5)
                pick = present - 5;
        end
        if (pick > 1000) pick = 1000;
        return pick;
    endfunction

    function automatic tick_result_t predict_tick(input logic [CYC_W-1:0] cyc,
                                                  input logic [TCAP_W-1:0] tcap,
                                                  input logic [SOH_W-1:0] present);
        tick_result_t r;
        int unsigned  soh;
        int unsigned  rs;
        r = '0;
        if (last_cyc == 0 || cyc != last_cyc) begin
            last_cyc = cyc;
            soh = choose_soh(32'(cyc), 32'(tcap), 32'(present));
            fade_cap = RCAP_W'((int'(rated_cap) * soh) / 1000);
            r.recomputed = 1'b1;
            r.new_soh = SOH_W'(soh);
            r.store_request = (SOH_W'(soh) != present);
        end
        rs = 0;
        if (rated_cap != 0) begin
            rs = (int'(fade_cap) * 1000) / rated_cap;
            if (rs > 1000) rs = 1000;
        end
        r.faded_capacity = fade_cap;
        r.real_soh = SOH_W'(rs);
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        tick_result_t want;
        if (!aresetn) begin
            rated_cap = bsfe_pkg::RATED_CAP_RST;
            rated_cyc = bsfe_pkg::RATED_CYC_RST;
            last_cyc = '0;
            fade_cap = bsfe_pkg::FADE_RST;
            soh_expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bsfe_pkg::CFG_RATED_CAPACITY: rated_cap = cfg_data;
                    bsfe_pkg::CFG_RATED_CYCLES:   rated_cyc = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (soh_expected_q.size() == 0) begin
                    report("result beat with nothing pending", m_tdata[31:0], 0);
                end else begin
                    want = soh_expected_q.pop_front();
                    if (m_tuser !== want.recomputed)
                        report("recomputed", 32'(m_tuser), 32'(want.recomputed));
                    if (m_tdata[9:0] !== want.new_soh)
                        report("new_soh", 32'(m_tdata[9:0]), 32'(want.new_soh));
                    if (m_tdata[10] !== want.store_request)
                        report("store_request", 32'(m_tdata[10]), 32'(want.store_request));
                    if (m_tdata[26:11] !== want.faded_capacity)
                        report("faded_capacity", 32'(m_tdata[26:11]),
                               32'(want.faded_capacity));
                    if (m_tdata[36:27] !== want.real_soh)
                        report("real_soh", 32'(m_tdata[36:27]), 32'(want.real_soh));
                end
            end
            if (s_tvalid && s_tready)
                soh_expected_q.push_back(predict_tick(s_tdata[15:0], s_tdata[39:16],
                                                      s_tdata[49:40]));
        end
        outstanding <= soh_expected_q.size();
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Top of the SOH fade estimator testbench: clock, reset, stimulus, stall
// patterns and the verdict. Depends on bsfe_pkg, bsfe_scoreboard and the block.
`default_nettype none

module testbench;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // [15:0] cycle_count, [39:16] total_capacity, [49:40] present_soh
    logic [bsfe_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [9:0] new_soh, [10] store_request, [26:11] faded_capacity, [36:27] real_soh
    logic [bsfe_pkg::M_TDATA_W-1:0]  m_tdata;
    // [0] recomputed
    logic                            m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bsfe_pkg::CFG_IDX_W-1:0]  cfg_index = bsfe_pkg::CFG_RATED_CAPACITY;
    logic [bsfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int errors;
    int outstanding;

    int          sender_idle = 0;
    int          recv_stall = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int unsigned cur_rcap = 1000;
    logic [15:0] last_cycle_sent = '0;

    battery_soh_fade_estimator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bsfe_scoreboard u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #4 aclk = ~aclk;

    // result side: random stalls, or a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    task automatic send_beat(input logic [15:0] cyc, input logic [23:0] tcap,
                             input logic [9:0] present);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, present, tcap, cyc};
        last_cycle_sent = cyc;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bsfe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_rating(input int unsigned rcap, input int unsigned rcyc);
        drain();
        write_reg(bsfe_pkg::CFG_RATED_CAPACITY, rcap[15:0]);
        write_reg(bsfe_pkg::CFG_RATED_CYCLES, rcyc[15:0]);
        cur_rcap = rcap;
    endtask

    // cycle counts that mostly repeat or advance, half of the capacities near the rated fade curve
    task automatic random_tick();
        int          k;
        int          cap;
        logic [15:0] cyc;
        logic [9:0]  present;
        k = $urandom_range(0, 99);
        if (k < 25)      cyc = last_cycle_sent;
        else if (k < 65) cyc = last_cycle_sent + 16'($urandom_range(1, 20));
        else if (k < 70) cyc = '0;
        else             cyc = 16'($urandom);
        k = $urandom_range(0, 9);
        if (k < 5) begin
            cap = int'(cur_rcap * $urandom_range(750, 1000) / 10);
            cap = cap + $urandom_range(0, 200) - 100;
            if (cap < 0) cap = 0;
            if (cap > 24'hFFFFFF) cap = 24'hFFFFFF;
        end else if (k < 8) begin
            cap = int'($urandom & 32'h00FF_FFFF);
        end else begin
            cap = $urandom_range(0, 2000);
        end
        k = $urandom_range(0, 99);
        if (k < 55)      present = 10'($urandom_range(700, 1000));
        else if (k < 85) present = 10'($urandom_range(0, 1023));
        else if (k < 93) present = 10'($urandom_range(0, 6));
        else             present = 10'($urandom_range(994, 1023));
        send_beat(cyc, 24'(cap), present);
    endtask

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int unsigned rcaps[8];
        int unsigned rcycs[8];
        int unsigned rc;
        int unsigned ry;
        rcaps = '{1000, 0, 65535, 1, 2500, 30000, 65535, 800};
        rcycs = '{1000, 300, 65535, 1, 0, 2000, 0, 65535};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset ratings: zero count, saturation, drop limit, clamp above full
        send_beat(16'd0, 24'd0, 10'd0);
        send_beat(16'd0, 24'hFFFFFF, 10'd1023);
        send_beat(16'd0, 24'd100000, 10'd1000);
        send_beat(16'd1, 24'd99900, 10'd1000);
        send_beat(16'd1, 24'd99900, 10'd1000);
        send_beat(16'd1500, 24'd50000, 10'd700);
        send_beat(16'd1500, 24'd50000, 10'd700);
        send_beat(16'd1000, 24'd80000, 10'd800);
        send_beat(16'd2000, 24'd10000, 10'd4);
        send_beat(16'd2001, 24'd10000, 10'd3);
        send_beat(16'd2002, 24'd90000, 10'd1001);
        send_beat(16'd2003, 24'd1000, 10'd1023);
        send_beat(16'hFFFF, 24'hFFFFFF, 10'd512);
        // zero ratings
        set_rating(0, 0);
        send_beat(16'd7, 24'd5000, 10'd900);
        send_beat(16'd7, 24'd5000, 10'd900);
        send_beat(16'd0, 24'hFFFFFF, 10'd1023);
        // full-scale ratings
        set_rating(65535, 65535);
        send_beat(16'hFFFF, 24'hFFFFFF, 10'd1000);
        send_beat(16'h8000, 24'h800000, 10'd512);
        send_beat(16'd1, 24'd1, 10'd1);
        // minimal ratings
        set_rating(1, 1);
        send_beat(16'd1, 24'hFFFFFF, 10'd1000);
        send_beat(16'd2, 24'd0, 10'd0);
        send_beat(16'd2, 24'd100, 10'd500);

        for (int p = 0; p < 8; p++) begin
            rc = rcaps[p];
            ry = rcycs[p];
            if (p == 5) begin
                rc = $urandom_range(0, 65535);
                ry = $urandom_range(0, 65535);
            end
            set_rating(rc, ry);
            case (p % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 73; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 73; end
                default: begin sender_idle = 21; recv_stall = 21; end
            endcase
            if (p == 0) hold_reqs++;
            repeat (90) begin
                random_tick();
                if ($urandom_range(0, 99) < 2) drain();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
